// ----- hw/rtl/wmbs_pkg.sv -----
// Shared constants, command codes and helpers for the wavelet matrix search block.
`default_nettype none
package wmbs_pkg;
  localparam int OUT_W = 13;
  localparam int SYM_W = 5;
  localparam int CMD_W = 2;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int SB_W = 3;
  localparam logic [SB_W-1:0] SB_RESET = 3'd3;

  // Register index, taken from the word address bits of paddr.
  localparam logic [CFG_AW-3:0] REG_SYMBOL_BITS = '0;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [OUT_W-1:0] MATCH_MAX = 13'h1FFF;

  // Bit of a symbol at a level; levels past the symbol width read as zero.
  function automatic logic sym_bit(input logic [SYM_W-1:0] s, input logic [3:0] lv);
    logic b;
    b = 1'b0;
    for (int k = 0; k < SYM_W; k++) begin
      if (lv == 4'(k)) b = s[k];
    end
    return b;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/wavelet_matrix_backward_search.sv -----
// Top level: wavelet matrix build and FM-index backward search sequencer.
// Usage:
//   Input stream: tdata = {symbol, cmd}, tuser = query_start. cmd load stores a
//   symbol (no result), cmd build forms the matrix over the loaded
//   text, cmd query narrows the search interval by one symbol.
//   Output stream: one transaction per build and per query, tdata =
//   {overflow, match_len, right, left}.
//   Config: APB register 0 at address 0 is symbol_bits, sampled at build.
// Sequencing:
//   A query holds the input while it walks the built levels, reading the zero
//   table and then applying the shared rank update to the interval per level.
//   A build holds the input while it sorts each level: a pass over the text
//   routes zero bits to the level order and one bits to scratch, then a pass
//   copies the ones after the zeros and the level's zero total is stored.
//   in_tready is high only while the sequencer is idle.
// Reset: clears interval, counts and flags; tables are undefined until built.
// Stall: a finished result waits in the output register; the next transaction
//   may be accepted meanwhile, and its result holds until the register frees.
`default_nettype none
module wavelet_matrix_backward_search #(
  parameter int MAX_LEN    = 4096,
  parameter int MAX_LEVELS = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // cmd[1:0], symbol[6:2]
  input  wire logic                          in_tuser,   // query_start
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [39:0]                        out_tdata,  // left, right, match_len, overflow
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [wmbs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [wmbs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [wmbs_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import wmbs_pkg::*;

  localparam int PW    = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW   = MAX_LEN + 1;
  localparam int ZDEP  = MAX_LEVELS * ROW;
  localparam int ZAW   = $clog2(ZDEP);
  localparam int LVW   = $clog2(MAX_LEVELS + 1);
  localparam int TIW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_B_LVL  = 4'd1;
  localparam logic [3:0] S_B_RD   = 4'd2;
  localparam logic [3:0] S_B_WR   = 4'd3;
  localparam logic [3:0] S_C_RD   = 4'd4;
  localparam logic [3:0] S_C_WR   = 4'd5;
  localparam logic [3:0] S_B_NEXT = 4'd6;
  localparam logic [3:0] S_Q_RD   = 4'd7;
  localparam logic [3:0] S_Q_UPD  = 4'd8;
  localparam logic [3:0] S_Q_FIN  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [SB_W-1:0]   sb_r;
  logic [PW-1:0]     load_cnt_r, load_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              pend_r, pend_nxt;
  logic              built_r, built_nxt;
  logic [LVW-1:0]    levels_r, levels_nxt;
  logic [PW-1:0]     tlen_r, tlen_nxt;
  logic [PW-1:0]     lo_r, lo_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic [OUT_W-1:0]  pm_r, pm_nxt;
  logic [LVW-1:0]    lv_r, lv_nxt;
  logic [ZAW-1:0]    base_r, base_nxt;
  logic [PW-1:0]     idx_r, idx_nxt;
  logic [PW-1:0]     zeros_r, zeros_nxt;
  logic [PW-1:0]     ones_r, ones_nxt;
  logic [SYM_W-1:0]  qsym_r, qsym_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;
  logic [PW-1:0]     totals_r [MAX_LEVELS];

  logic [SYM_W-1:0]  sym_store [MAX_LEN];
  logic [SYM_W-1:0]  lvl_order [MAX_LEN];
  logic [SYM_W-1:0]  scratch   [MAX_LEN];
  logic [SYM_W-1:0]  st_q_r, lo_q_r, sc_q_r;

  logic [CMD_W-1:0]  in_cmd;
  logic [SYM_W-1:0]  in_sym;
  logic              in_acc;
  logic              cfg_wr;

  // memory control
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              lo_we;
  logic [AW-1:0]     lo_waddr;
  logic [SYM_W-1:0]  lo_wdata;
  logic              sc_we;
  logic [AW-1:0]     sc_waddr;
  logic              tot_we;

  // zero table control
  logic              zt_we;
  logic [ZAW-1:0]    zt_waddr;
  logic [PW-1:0]     zt_wdata;
  logic              zt_re;
  logic [ZAW-1:0]    zt_raddr_a, zt_raddr_b;
  logic [PW-1:0]     lo_clamp, hi_clamp;
  logic [PW-1:0]     lo_rank, hi_rank;
  logic              cur_bit;
  logic [SYM_W-1:0]  cur_sym;
  logic [PW-1:0]     eff_cnt;

  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_sym    = in_tdata[CMD_W+SYM_W-1:CMD_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_SYMBOL_BITS) ? CFG_DW'(sb_r) : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign lo_clamp = (lo_r > tlen_r) ? tlen_r : lo_r;
  assign hi_clamp = (hi_r > tlen_r) ? tlen_r : hi_r;
  assign cur_sym  = (lv_r == '0) ? st_q_r : lo_q_r;
  assign eff_cnt  = pend_r ? '0 : load_cnt_r;

  wmbs_ztab #(.DEPTH(ZDEP), .AW(ZAW), .DW(PW)) u_ztab (
    .clk     (clk),
    .we      (zt_we),
    .waddr   (zt_waddr),
    .wdata   (zt_wdata),
    .re      (zt_re),
    .raddr_a (zt_raddr_a),
    .raddr_b (zt_raddr_b),
    .bit_sel (sym_bit(qsym_r, 4'(lv_r))),
    .lo_pos  (lo_r),
    .hi_pos  (hi_r),
    .total   (totals_r[lv_r[TIW-1:0]]),
    .lo_next (lo_rank),
    .hi_next (hi_rank)
  );

  always_ff @(posedge clk) begin
    if (st_we) sym_store[st_waddr] <= in_sym;
    if (lo_we) lvl_order[lo_waddr] <= lo_wdata;
    if (sc_we) scratch[sc_waddr] <= cur_sym;
    if (mem_re) begin
      st_q_r <= sym_store[mem_raddr];
      lo_q_r <= lvl_order[mem_raddr];
      sc_q_r <= scratch[mem_raddr];
    end
    if (tot_we) totals_r[lv_r[TIW-1:0]] <= zeros_r;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    ovf_nxt       = ovf_r;
    pend_nxt      = pend_r;
    built_nxt     = built_r;
    levels_nxt    = levels_r;
    tlen_nxt      = tlen_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pm_nxt        = pm_r;
    lv_nxt        = lv_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    zeros_nxt     = zeros_r;
    ones_nxt      = ones_r;
    qsym_nxt      = qsym_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    st_we = 1'b0; st_waddr = eff_cnt[AW-1:0];
    mem_re = 1'b0; mem_raddr = idx_r[AW-1:0];
    lo_we = 1'b0; lo_waddr = zeros_r[AW-1:0]; lo_wdata = cur_sym;
    sc_we = 1'b0; sc_waddr = ones_r[AW-1:0];
    tot_we = 1'b0;
    zt_we = 1'b0; zt_waddr = base_r; zt_wdata = '0;
    zt_re = 1'b0;
    zt_raddr_a = base_r + ZAW'(lo_clamp);
    zt_raddr_b = base_r + ZAW'(hi_clamp);
    cur_bit = sym_bit(cur_sym, 4'(lv_r));

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_LOAD: begin
              pend_nxt = 1'b0;
              if (pend_r) ovf_nxt = 1'b0;
              if (eff_cnt < PW'(MAX_LEN)) begin
                st_we        = 1'b1;
                load_cnt_nxt = eff_cnt + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_BUILD: begin
              tlen_nxt   = load_cnt_r;
              levels_nxt = (int'(sb_r) > MAX_LEVELS) ? LVW'(MAX_LEVELS) : LVW'(sb_r);
              built_nxt  = 1'b1;
              pend_nxt   = 1'b1;
              lo_nxt     = '0;
              hi_nxt     = load_cnt_r;
              pm_nxt     = '0;
              lv_nxt     = '0;
              base_nxt   = '0;
              state_nxt  = (levels_nxt == '0) ? S_DONE : S_B_LVL;
            end
            CMD_QUERY: begin
              qsym_nxt = in_sym;
              lv_nxt   = '0;
              base_nxt = '0;
              if (in_tuser) begin
                lo_nxt = '0;
                hi_nxt = tlen_r;
                pm_nxt = '0;
              end
              state_nxt = built_r ? S_Q_RD : S_Q_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      S_B_LVL: begin
        zt_we     = 1'b1;
        idx_nxt   = '0;
        zeros_nxt = '0;
        ones_nxt  = '0;
        state_nxt = S_B_RD;
      end
      S_B_RD: begin
        if (idx_r == tlen_r) begin
          idx_nxt   = '0;
          state_nxt = S_C_RD;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_B_WR;
        end
      end
      S_B_WR: begin
        // route the symbol: zeros compact in place, ones park in scratch
        if (cur_bit) begin
          sc_we    = 1'b1;
          ones_nxt = ones_r + 1'b1;
        end else begin
          lo_we     = 1'b1;
          zeros_nxt = zeros_r + 1'b1;
        end
        zt_we     = 1'b1;
        zt_waddr  = base_r + ZAW'(idx_r) + ZAW'(1);
        zt_wdata  = zeros_nxt;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_B_RD;
      end
      S_C_RD: begin
        if (idx_r == ones_r) begin
          state_nxt = S_B_NEXT;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_C_WR;
        end
      end
      S_C_WR: begin
        lo_we     = 1'b1;
        lo_waddr  = AW'(zeros_r + idx_r);
        lo_wdata  = sc_q_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_C_RD;
      end
      S_B_NEXT: begin
        tot_we    = 1'b1;
        lv_nxt    = lv_r + 1'b1;
        base_nxt  = base_r + ZAW'(ROW);
        state_nxt = (lv_nxt == levels_r) ? S_DONE : S_B_LVL;
      end
      S_Q_RD: begin
        if (lv_r == levels_r) begin
          state_nxt = S_Q_FIN;
        end else begin
          zt_re     = 1'b1;
          lo_nxt    = lo_clamp;
          hi_nxt    = hi_clamp;
          state_nxt = S_Q_UPD;
        end
      end
      S_Q_UPD: begin
        lo_nxt    = lo_rank;
        hi_nxt    = hi_rank;
        lv_nxt    = lv_r + 1'b1;
        base_nxt  = base_r + ZAW'(ROW);
        state_nxt = S_Q_RD;
      end
      S_Q_FIN: begin
        lo_nxt = lo_clamp;
        hi_nxt = hi_clamp;
        if (hi_clamp > lo_clamp && pm_r < MATCH_MAX) pm_nxt = pm_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ovf_r, pm_r, OUT_W'(hi_r), OUT_W'(lo_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sb_r        <= SB_RESET;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      built_r     <= 1'b0;
      levels_r    <= '0;
      tlen_r      <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      pm_r        <= '0;
      lv_r        <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr && cfg_paddr[CFG_AW-1:2] == REG_SYMBOL_BITS) sb_r <= cfg_pwdata[SB_W-1:0];
      load_cnt_r  <= load_cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      built_r     <= built_nxt;
      levels_r    <= levels_nxt;
      tlen_r      <= tlen_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      pm_r        <= pm_nxt;
      lv_r        <= lv_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    zeros_r    <= zeros_nxt;
    ones_r     <= ones_nxt;
    qsym_r     <= qsym_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/wmbs_ztab.sv -----
// Zero prefix count table with two registered read ports and the shared rank update.
`default_nettype none
module wmbs_ztab #(
  parameter int DEPTH = 20485,
  parameter int AW    = 15,
  parameter int DW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  input  wire logic          bit_sel,
  input  wire logic [DW-1:0] lo_pos,
  input  wire logic [DW-1:0] hi_pos,
  input  wire logic [DW-1:0] total,
  output logic      [DW-1:0] lo_next,
  output logic      [DW-1:0] hi_next
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] za_r;
  logic [DW-1:0] zb_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      za_r <= mem[raddr_a];
      zb_r <= mem[raddr_b];
    end
  end

  // One bits go after all zeros of the level, zero bits keep their zero rank.
  assign lo_next = bit_sel ? (lo_pos - za_r) + total : za_r;
  assign hi_next = bit_sel ? (hi_pos - zb_r) + total : zb_r;
endmodule
`default_nettype wire
